[hw/rtl/wbpc_pkg.sv]
// Shared types, constants and helpers of the wildcard byte pattern counter.
package wbpc_pkg;

  localparam int unsigned MAX_PATTERN_BYTES_DEF = 24;
  localparam int unsigned ADDRESS_BITS_DEF      = 32;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned ADDR_OUT_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned BANK_BYTES = 8;
  localparam int unsigned BANK_COUNT = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LO  = 3'd0,
    REG_PATTERN_MID = 3'd1,
    REG_PATTERN_HI  = 3'd2,
    REG_PATTERN_LEN = 3'd3,
    REG_BASE_ADDR   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_range;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]      match_count;
    logic [ADDR_OUT_W-1:0] first_match_address;
    logic                  any_match;
  } out_item_t;

  // per-byte control broadcast along the cell row and to the tally
  typedef struct packed {
    logic             accept;
    logic             last;
    logic [LEN_W-1:0] len;
  } step_t;

  // zero pattern byte is a wildcard
  function automatic logic byte_hit(input logic [BYTE_W-1:0] want,
                                    input logic [BYTE_W-1:0] got);
    byte_hit = (want == '0) || (want == got);
  endfunction

endpackage

[hw/rtl/wbpc_cell.sv]
// One window cell: holds a byte of history and compares it with its pattern byte.
module wbpc_cell #(
  parameter int unsigned MAX_PATTERN_BYTES = wbpc_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int unsigned POS               = 1
) (
  input  logic                                            clk_i,
  input  wbpc_pkg::step_t                                 step_i,
  input  logic [MAX_PATTERN_BYTES-1:0][wbpc_pkg::BYTE_W-1:0] pattern_i,
  input  logic [wbpc_pkg::BYTE_W-1:0]                     byte_i,
  output logic [wbpc_pkg::BYTE_W-1:0]                     byte_o,
  output logic                                            hit_o
);
  import wbpc_pkg::*;

  localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam logic [LEN_W-1:0] POS_L = LEN_W'(POS);

  logic [BYTE_W-1:0] byte_q;
  logic [LEN_W-1:0]  sel;

  always_ff @(posedge clk_i) begin
    if (step_i.accept) begin
      byte_q <= byte_i;
    end
  end

  // pattern byte (len - 1 - POS) lines up with this position
  always_comb begin
    sel   = step_i.len - POS_L - LEN_W'(1);
    hit_o = (POS_L >= step_i.len) || byte_hit(pattern_i[sel[IDX_W-1:0]], byte_q);
  end

  assign byte_o = byte_q;

endmodule

[hw/rtl/wbpc_tally.sv]
// Match tally: byte count, saturating match count and first match address.
module wbpc_tally #(
  parameter int unsigned ADDRESS_BITS = wbpc_pkg::ADDRESS_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wbpc_pkg::step_t                step_i,
  input  logic                           all_hit_i,
  input  logic [wbpc_pkg::ADDR_OUT_W-1:0] base_i,
  output wbpc_pkg::out_item_t            result_o
);
  import wbpc_pkg::*;

  localparam logic [ADDR_OUT_W-1:0] ADDR_MASK = (ADDRESS_BITS >= ADDR_OUT_W) ? '1 :
      ADDR_OUT_W'((64'd1 << ADDRESS_BITS) - 64'd1);

  logic [CNT_W-1:0]      seen_q, seen_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [ADDR_OUT_W-1:0] first_q, first_d;
  logic                  hit;
  logic [CNT_W-1:0]      offset;
  logic [ADDR_OUT_W:0]   addr_sum;

  always_comb begin
    seen_d   = (seen_q == '1) ? seen_q : seen_q + CNT_W'(1);
    hit      = (seen_d >= CNT_W'(step_i.len)) && all_hit_i;
    offset   = seen_d - CNT_W'(step_i.len);
    addr_sum = {1'b0, base_i} + {1'b0, offset};
    count_d  = count_q;
    first_d  = first_q;
    if (hit) begin
      if (count_q == '0) begin
        first_d = addr_sum[ADDR_OUT_W-1:0] & ADDR_MASK;
      end
      if (count_q != '1) begin
        count_d = count_q + CNT_W'(1);
      end
    end
    result_o.match_count         = count_d;
    result_o.first_match_address = (count_d != '0) ? first_d : '0;
    result_o.any_match           = (count_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      count_q <= '0;
      first_q <= '0;
    end else if (step_i.accept) begin
      if (step_i.last) begin
        seen_q  <= '0;
        count_q <= '0;
        first_q <= '0;
      end else begin
        seen_q  <= seen_d;
        count_q <= count_d;
        first_q <= first_d;
      end
    end
  end

endmodule

[hw/rtl/wildcard_byte_pattern_counter_top.sv]
// Top level of the wildcard byte pattern counter.
//
// Usage: bytes of a memory range arrive on the input channel (in_valid_i,
// in_stall_o, in_data_i), one per request, the final byte flagged with
// end_of_range. Each byte is compared at once against the configured pattern
// across a row of window cells; a zero pattern byte matches anything.
// One result request (match count, first match address, any-match flag) is
// issued per range on the output channel; it is registered after the final byte.
// Throughput is one byte per cycle while input is not stalled, set by the
// compare of the cell row and the tally update behind it.
// The user must write configuration (pattern banks, length, base address)
// through cfg_valid_i/cfg_ready_o while no scan is in progress; not enforced.
// Ready is always high. Reset clears the scan state and sets the pattern length
// to one. When the receiver stalls, a result waits in the output register and a
// second one in a skid register; only with both full is input stalled.
module wildcard_byte_pattern_counter_top #(
  parameter int unsigned MAX_PATTERN_BYTES = wbpc_pkg::MAX_PATTERN_BYTES_DEF,
  parameter int unsigned ADDRESS_BITS      = wbpc_pkg::ADDRESS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  wbpc_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output wbpc_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wbpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wbpc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wbpc_pkg::*;

  localparam int unsigned IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
  localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_PATTERN_BYTES);

  logic [CFG_DATA_W-1:0] pat_lo_q, pat_mid_q, pat_hi_q;
  logic [LEN_W-1:0]      len_q;
  logic [ADDR_OUT_W-1:0] base_q;

  logic [BANK_COUNT*BANK_BYTES-1:0][BYTE_W-1:0] pat_all;
  logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0]     pat_bytes;
  logic [LEN_W-1:0]      len_eff, len_m1;
  step_t                 step;
  logic                  in_acc;

  logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] win;
  logic [MAX_PATTERN_BYTES-1:0]             hits;
  out_item_t             result;

  logic                  out_valid_q, out_valid_d;
  logic                  skid_valid_q, skid_valid_d;
  out_item_t             out_q, out_d;
  out_item_t             skid_q, skid_d;
  logic                  push, out_free;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_mid_q <= '0;
      pat_hi_q  <= '0;
      len_q     <= LEN_W'(1);
      base_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PATTERN_LO:  pat_lo_q  <= cfg_data_i;
        REG_PATTERN_MID: pat_mid_q <= cfg_data_i;
        REG_PATTERN_HI:  pat_hi_q  <= cfg_data_i;
        REG_PATTERN_LEN: len_q     <= cfg_data_i[LEN_W-1:0];
        REG_BASE_ADDR:   base_q    <= cfg_data_i[ADDR_OUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign pat_all   = {pat_hi_q, pat_mid_q, pat_lo_q};
  assign pat_bytes = pat_all[MAX_PATTERN_BYTES-1:0];

  always_comb begin
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_q > MAX_L) begin
      len_eff = MAX_L;
    end else begin
      len_eff = len_q;
    end
    len_m1 = len_eff - LEN_W'(1);
  end

  assign in_stall_o  = skid_valid_q;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign step.accept = in_acc;
  assign step.last   = in_data_i.end_of_range;
  assign step.len    = len_eff;

  // newest byte sits at position 0; the cells hold the older ones
  assign win[0]  = in_data_i.data_byte;
  assign hits[0] = byte_hit(pat_bytes[len_m1[IDX_W-1:0]], in_data_i.data_byte);

  for (genvar j = 1; j < MAX_PATTERN_BYTES; j++) begin : g_cell
    wbpc_cell #(
      .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
      .POS              (j)
    ) u_cell (
      .clk_i    (clk_i),
      .step_i   (step),
      .pattern_i(pat_bytes),
      .byte_i   (win[j-1]),
      .byte_o   (win[j]),
      .hit_o    (hits[j])
    );
  end

  wbpc_tally #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_tally (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .all_hit_i(&hits),
    .base_i   (base_q),
    .result_o (result)
  );

  // output register plus skid
  assign push     = in_acc && in_data_i.end_of_range;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = result;
        out_valid_d = push;
      end
    end else if (push) begin
      skid_d       = result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while output register is empty");

  a_stalled_end_to_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.end_of_range && out_valid_q && out_stall_i) |=> skid_valid_q)
    else $error("result of a range lost behind a stalled output");

  a_no_match_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.any_match) |->
      (out_data_o.match_count == '0 && out_data_o.first_match_address == '0))
    else $error("result without a match carries a count or address");
`endif

endmodule

[tb/sv/wbpc_tally_checker.sv]
`timescale 1ns / 100ps
// Checker for the wildcard byte pattern counter: tracks configuration, predicts tallies, compares.
module wbpc_tally_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  wbpc_pkg::in_item_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  wbpc_pkg::out_item_t             out_data_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [wbpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wbpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);

  localparam int unsigned PAT_BYTES = wbpc_pkg::MAX_PATTERN_BYTES_DEF;

  logic [8*PAT_BYTES-1:0] pattern_bits;
  logic [4:0]             pattern_len;
  logic [31:0]            base_addr;

  logic [7:0]  recent_bytes [0:PAT_BYTES-2];
  logic [31:0] bytes_seen;
  logic [31:0] match_tally;
  logic [31:0] first_hit_addr;

  wbpc_pkg::out_item_t expected_tallies [$];

  task automatic clear_scan();
    int unsigned i;
    for (i = 0; i < PAT_BYTES - 1; i++) recent_bytes[i] = 8'h00;
    bytes_seen     = '0;
    match_tally    = '0;
    first_hit_addr = '0;
  endtask

  task automatic absorb_byte(input wbpc_pkg::in_item_t item);
    int unsigned         len;
    int unsigned         i;
    logic [31:0]         seen;
    logic [7:0]          want;
    logic [7:0]          got;
    logic                hit;
    wbpc_pkg::out_item_t tally;
    len  = (pattern_len == 0) ? 1 : (pattern_len > PAT_BYTES) ? PAT_BYTES : pattern_len;
    seen = (bytes_seen == '1) ? '1 : bytes_seen + 32'd1;
    if (seen >= len) begin
      hit = 1'b1;
      // pattern byte 0 lines up with the oldest byte of the window
      for (i = 0; i < len; i++) begin
        want = pattern_bits[8*i +: 8];
        got  = (i == len - 1) ? item.data_byte : recent_bytes[len-2-i];
        if (want != 8'h00 && got != want) hit = 1'b0;
      end
      if (hit) begin
        if (match_tally == 0) first_hit_addr = base_addr + (seen - len);
        if (match_tally != '1) match_tally = match_tally + 32'd1;
      end
    end
    for (i = PAT_BYTES - 2; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = item.data_byte;
    bytes_seen = seen;
    if (item.end_of_range) begin
      tally.match_count         = match_tally;
      tally.first_match_address = (match_tally != 0) ? first_hit_addr : '0;
      tally.any_match           = (match_tally != 0);
      expected_tallies.push_back(tally);
      clear_scan();
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] exp, input logic [31:0] act);
    $display("%0t %s mismatch: expected %h actual %h", $time, what, exp, act);
    fail_count_o = fail_count_o + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    wbpc_pkg::out_item_t want;
    if (!rst_ni) begin
      pattern_bits = '0;
      pattern_len  = 5'd1;
      base_addr    = '0;
      clear_scan();
      expected_tallies.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          wbpc_pkg::REG_PATTERN_LO:  pattern_bits[63:0]    = cfg_data_i;
          wbpc_pkg::REG_PATTERN_MID: pattern_bits[127:64]  = cfg_data_i;
          wbpc_pkg::REG_PATTERN_HI:  pattern_bits[191:128] = cfg_data_i;
          wbpc_pkg::REG_PATTERN_LEN: pattern_len           = cfg_data_i[4:0];
          wbpc_pkg::REG_BASE_ADDR:   base_addr             = cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) absorb_byte(in_data_i);
      if (out_valid_i && !out_stall_i) begin
        if (expected_tallies.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, out_data_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = expected_tallies.pop_front();
          if (out_data_i.match_count !== want.match_count)
            flag_mismatch("match_count", want.match_count, out_data_i.match_count);
          if (out_data_i.first_match_address !== want.first_match_address)
            flag_mismatch("first_match_address", want.first_match_address,
                          out_data_i.first_match_address);
          if (out_data_i.any_match !== want.any_match)
            flag_mismatch("any_match", {31'd0, want.any_match}, {31'd0, out_data_i.any_match});
        end
      end
      pending_o = expected_tallies.size();
    end
  end

endmodule

[tb/sv/tb_wildcard_byte_pattern_counter_top.sv]
`timescale 1ns / 100ps
// Testbench top for the wildcard byte pattern counter: stimulus, idling, watchdog and verdict.
module tb_wildcard_byte_pattern_counter_top;

  localparam int unsigned TARGET_BYTES   = 1850;
  localparam int unsigned PHASE_BYTES    = 110;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_GAP        = 30;

  logic clk = 1'b0;
  logic rst_n;

  logic                                in_valid;
  logic                                in_stall;
  wbpc_pkg::in_item_t                  in_data;
  logic                                out_valid;
  logic                                out_stall;
  wbpc_pkg::out_item_t                 out_data;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [wbpc_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [wbpc_pkg::CFG_DATA_W-1:0]     cfg_data;

  int unsigned fail_count;
  int unsigned pending;

  int unsigned sender_idle_pct;
  int unsigned stall_pct;
  logic        hold_req;
  int unsigned bytes_sent;
  int unsigned quiet_cycles;

  logic [191:0] cur_pattern;
  int unsigned  cur_len_eff;
  logic [7:0]   range_bytes [$];

  always #1 clk = ~clk;

  wildcard_byte_pattern_counter_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  wbpc_tally_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    logic        holding;
    int unsigned pct_now;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      holding = hold_req;
      pct_now = stall_pct;
      @(negedge clk);
      if (holding) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < pct_now);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // returns at the accepting rising edge, valid still high
  task automatic push_byte(input wbpc_pkg::in_item_t item);
    int unsigned gap;
    gap = 0;
    @(negedge clk);
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      gap++;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_range();
    int unsigned        i;
    wbpc_pkg::in_item_t item;
    for (i = 0; i < range_bytes.size(); i++) begin
      item.data_byte    = range_bytes[i];
      item.end_of_range = (i == range_bytes.size() - 1);
      push_byte(item);
    end
  endtask

  task automatic run_scan(input int unsigned target);
    int         i;
    int         spoil;
    logic [7:0] b;
    range_bytes.delete();
    while (range_bytes.size() < target) begin
      if ($urandom_range(99) < 40) begin
        // planted copy of the pattern, wildcards filled at random, now and then spoilt
        spoil = ($urandom_range(4) == 0) ? int'($urandom_range(cur_len_eff - 1)) : -1;
        for (i = 0; i < cur_len_eff; i++) begin
          b = cur_pattern[8*i +: 8];
          if (b == 8'h00) b = 8'($urandom_range(255));
          if (i == spoil) b = b ^ (8'h01 << $urandom_range(7));
          range_bytes.push_back(b);
        end
      end else begin
        b = 8'($urandom_range(1) ? $urandom_range(4) : $urandom_range(255));
        range_bytes.push_back(b);
      end
    end
    send_range();
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input wbpc_pkg::cfg_reg_e idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input logic [191:0] pat, input logic [63:0] len_word,
                               input logic [63:0] base_word);
    set_reg(wbpc_pkg::REG_PATTERN_LO,  pat[63:0]);
    set_reg(wbpc_pkg::REG_PATTERN_MID, pat[127:64]);
    set_reg(wbpc_pkg::REG_PATTERN_HI,  pat[191:128]);
    set_reg(wbpc_pkg::REG_PATTERN_LEN, len_word);
    set_reg(wbpc_pkg::REG_BASE_ADDR,   base_word);
    @(negedge clk);
    cfg_valid   <= 1'b0;
    cur_pattern = pat;
    cur_len_eff = (len_word[4:0] == 0) ? 1 : (len_word[4:0] > 24) ? 24 : len_word[4:0];
  endtask

  initial begin : stimulus
    int unsigned  phase;
    int unsigned  mode;
    int unsigned  style;
    int unsigned  start;
    int unsigned  len_raw;
    int           i;
    logic [191:0] pat;
    logic [63:0]  len_word;
    logic [63:0]  base_word;
    logic [31:0]  base;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    hold_req        = 1'b0;
    sender_idle_pct = 0;
    stall_pct       = 0;
    bytes_sent      = 0;
    quiet_cycles    = 0;
    cur_pattern     = '0;
    cur_len_eff     = 1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset setting: length one, all wildcard, so a lone byte matches
    range_bytes.delete();
    range_bytes.push_back(8'h00);
    send_range();
    settle();

    // full-length pattern, length field over range, base at the top
    for (i = 0; i < 24; i++)
      pat[8*i +: 8] = (i == 0) ? 8'hFF : (i == 5) ? 8'h00 : i[7:0];
    apply_setting(pat, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    range_bytes.delete();
    range_bytes.push_back(8'hFF);
    send_range();
    range_bytes.delete();
    for (i = 0; i < 24; i++) range_bytes.push_back(pat[8*i +: 8]);
    send_range();
    settle();

    // zero length acts as one; match address wraps past the top
    apply_setting(pat, 64'h0, 64'h0000_0000_FFFF_FFFF);
    range_bytes.delete();
    range_bytes.push_back(8'h00);
    range_bytes.push_back(8'hFF);
    send_range();

    phase = 0;
    while (bytes_sent < TARGET_BYTES) begin
      settle();
      mode = phase % 4;
      sender_idle_pct = (mode == 1) ? 76 : (mode == 3) ? 12 : 0;
      stall_pct       = (mode == 2) ? 76 : (mode == 3) ? 12 : 0;

      style = $urandom_range(5);
      for (i = 0; i < 24; i++) begin
        if (style == 0 || (style != 1 && $urandom_range(99) < 30))
          pat[8*i +: 8] = 8'h00;
        else if ($urandom_range(1))
          pat[8*i +: 8] = 8'($urandom_range(4, 1));
        else
          pat[8*i +: 8] = 8'($urandom_range(255, 1));
      end
      case ($urandom_range(9))
        0: len_raw = 0;
        1: len_raw = $urandom_range(31, 25);
        2: len_raw = 24;
        3: len_raw = 1;
        default: len_raw = $urandom_range(24, 1);
      endcase
      case ($urandom_range(5))
        0: base = 32'h0;
        1: base = 32'hFFFF_FFFF;
        2: base = 32'hFFFF_FFFF - $urandom_range(60);
        default: base = $urandom;
      endcase
      len_word       = {$urandom, $urandom};
      len_word[4:0]  = len_raw[4:0];
      base_word      = {$urandom, base};
      apply_setting(pat, len_word, base_word);

      start = bytes_sent;
      if (phase == 5) begin
        // long receiver hold-off with back-to-back short ranges
        sender_idle_pct = 0;
        hold_req        = 1'b1;
        repeat (30) run_scan($urandom_range(3, 1));
      end
      while (bytes_sent < start + PHASE_BYTES)
        run_scan(($urandom_range(9) == 0) ? $urandom_range(90, 41) : $urandom_range(40, 1));
      phase++;
    end

    settle();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
